[rtl/emmr_pkg.sv]
// ----------------------------------------------------------------------------
// emmr_pkg
// Shared types, constants and address map of the MAC register model.
// ----------------------------------------------------------------------------
package emmr_pkg;

  localparam int unsigned ADDR_W       = 13;
  localparam int unsigned SIZE_W       = 3;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned PHY_DATA_W   = 16;
  localparam int unsigned PHY_IDX_W    = 5;
  localparam int unsigned PHY_REG_CNT  = 32;
  localparam int unsigned MDIO_ADDR_W  = 11;
  localparam int unsigned MAP_BYTES    = 8192;

  localparam logic [PHY_IDX_W-1:0] PHY_ADDRESS = 5'd1;

  localparam logic [ADDR_W-1:0] ADDR_MDIO_ADDR = 13'h07e4;
  localparam logic [ADDR_W-1:0] ADDR_MDIO_WR   = 13'h07e8;
  localparam logic [ADDR_W-1:0] ADDR_MDIO_RD   = 13'h07ec;
  localparam logic [ADDR_W-1:0] ADDR_MDIO_CTRL = 13'h07f0;
  localparam logic [ADDR_W-1:0] ADDR_PING_LEN  = 13'h07f4;
  localparam logic [ADDR_W-1:0] ADDR_PING_STAT = 13'h07fc;
  localparam logic [ADDR_W-1:0] ADDR_PONG_LEN  = 13'h0ff4;
  localparam logic [ADDR_W-1:0] ADDR_PONG_STAT = 13'h0ffc;
  localparam logic [ADDR_W-1:0] ADDR_RXA_STAT  = 13'h17fc;
  localparam logic [ADDR_W-1:0] ADDR_RXB_STAT  = 13'h1ffc;
  localparam logic [ADDR_W-1:0] ADDR_TXA_LAST  = 13'h07e0;
  localparam logic [ADDR_W-1:0] ADDR_TXB_FIRST = 13'h0800;
  localparam logic [ADDR_W-1:0] ADDR_TXB_LAST  = 13'h0ff0;
  localparam logic [ADDR_W-1:0] ADDR_RXA_FIRST = 13'h1000;
  localparam logic [ADDR_W-1:0] ADDR_RXA_LAST  = 13'h17f8;
  localparam logic [ADDR_W-1:0] ADDR_RXB_FIRST = 13'h1800;
  localparam logic [ADDR_W-1:0] ADDR_RXB_LAST  = 13'h1ff8;

  localparam logic [PHY_DATA_W-1:0] BMSR_SET_BITS = 16'h0024;
  localparam logic [PHY_IDX_W-1:0]  PHY_BMCR_IDX  = 5'd0;
  localparam logic [PHY_IDX_W-1:0]  PHY_BMSR_IDX  = 5'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BEYOND  = 3'd1,
    ST_NOREAD  = 3'd2,
    ST_NOWRITE = 3'd3,
    ST_PHYREG  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ACC_BEYOND,
    ACC_NOREAD,
    ACC_NOWRITE,
    ACC_RD_PING,
    ACC_RD_PONG,
    ACC_RD_MDIO,
    ACC_RD_CTRL,
    ACC_RD_ZERO,
    ACC_WR_PING,
    ACC_WR_PONG,
    ACC_WR_CTRL,
    ACC_WR_MADDR,
    ACC_WR_MDATA,
    ACC_WR_NOP
  } acc_kind_t;

  typedef struct packed {
    acc_kind_t kind;
    logic      is_write;
  } dec_t;

  // Reset contents of the PHY register file
  function automatic logic [PHY_DATA_W-1:0] phy_preset(input logic [PHY_IDX_W-1:0] idx);
    logic [PHY_DATA_W-1:0] val;
    begin
      case (idx)
        5'd0:    val = 16'h3100;
        5'd1:    val = 16'h7849;
        5'd2:    val = 16'h0181;
        5'd3:    val = 16'hb8a0;
        5'd4:    val = 16'h01e1;
        5'd5:    val = 16'h4de1;
        default: val = '0;
      endcase
      return val;
    end
  endfunction

endpackage

[rtl/emmr_in_if.sv]
// ----------------------------------------------------------------------------
// emmr_in_if
// Bus access channel: command, byte address, size and write data.
// ----------------------------------------------------------------------------
interface emmr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [emmr_pkg::ADDR_W-1:0]    byte_address;
  logic [emmr_pkg::SIZE_W-1:0]    access_bytes;
  logic [emmr_pkg::DATA_W-1:0]    write_data;

  modport source (output valid, command, byte_address, access_bytes, write_data,
                  input ready);
  modport sink   (input valid, command, byte_address, access_bytes, write_data,
                  output ready);
endinterface

[rtl/emmr_out_if.sv]
// ----------------------------------------------------------------------------
// emmr_out_if
// Response channel: read data and status code.
// ----------------------------------------------------------------------------
interface emmr_out_if;
  logic                        valid;
  logic                        ready;
  logic [emmr_pkg::DATA_W-1:0] read_data;
  logic [2:0]                  status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

[rtl/ethernet_mac_mdio_register_model_top.sv]
// ----------------------------------------------------------------------------
// ethernet_mac_mdio_register_model_top
// Register model of a small Ethernet MAC with an MDIO port and one PHY.
// ----------------------------------------------------------------------------
// One bus access is handled at a time. It is taken in, decoded and applied
// in the next cycle, and its response word is offered from the output state
// that follows; an MDIO read hitting the PHY, or a BMCR write with bit 15
// set, passes through a store state first for the registered read of the
// PHY register file (read-modify-write of BMSR). A new access is taken in
// the same cycle the response is taken. There is no clearing pass after
// reset.
module ethernet_mac_mdio_register_model_top (
  input logic clk,
  input logic rst_n,
  emmr_in_if.sink    in_word,
  emmr_out_if.source out_word
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MEM, S_OUT} state_t;

  state_t                                state_r, state_nxt;
  logic                                  cmd_r;
  logic [emmr_pkg::ADDR_W-1:0]           addr_r;
  logic [emmr_pkg::SIZE_W-1:0]           size_r;
  logic [emmr_pkg::DATA_W-1:0]           wdata_r;
  logic [emmr_pkg::DATA_W-1:0]           ping_r, ping_nxt;
  logic [emmr_pkg::DATA_W-1:0]           pong_r, pong_nxt;
  logic [emmr_pkg::MDIO_ADDR_W-1:0]      maddr_r, maddr_nxt;
  logic [emmr_pkg::PHY_DATA_W-1:0]       mwr_r, mwr_nxt;
  logic [emmr_pkg::PHY_DATA_W-1:0]       mrd_r, mrd_nxt;
  logic [emmr_pkg::DATA_W-1:0]           mctrl_r, mctrl_nxt;
  logic                                  mem_rd_op_r, mem_rd_op_nxt;
  logic [emmr_pkg::DATA_W-1:0]           rdata_r, rdata_nxt;
  emmr_pkg::status_t                     status_r, status_nxt;

  emmr_pkg::dec_t                        dec;
  logic                                  in_fire;
  logic                                  phy_hit;
  logic [emmr_pkg::PHY_IDX_W-1:0]        phy_reg;
  logic                                  st_rd_en;
  logic [emmr_pkg::PHY_IDX_W-1:0]        st_rd_idx;
  logic [emmr_pkg::PHY_DATA_W-1:0]       st_rd_data;
  logic                                  st_wr_en;
  logic [emmr_pkg::PHY_IDX_W-1:0]        st_wr_idx;
  logic [emmr_pkg::PHY_DATA_W-1:0]       st_wr_data;

  emmr_decode u_decode (
    .command      (cmd_r),
    .byte_address (addr_r),
    .access_bytes (size_r),
    .dec          (dec)
  );

  emmr_phy_store u_phy_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd_en),
    .rd_idx  (st_rd_idx),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_idx  (st_wr_idx),
    .wr_data (st_wr_data)
  );

  assign in_word.ready     = (state_r == S_IDLE) || (state_r == S_OUT && out_word.ready);
  assign in_fire           = in_word.valid && in_word.ready;
  assign out_word.valid    = (state_r == S_OUT);
  assign out_word.read_data = rdata_r;
  assign out_word.status   = status_r;

  assign phy_reg = maddr_r[emmr_pkg::PHY_IDX_W-1:0];
  assign phy_hit = (maddr_r[2*emmr_pkg::PHY_IDX_W-1:emmr_pkg::PHY_IDX_W] ==
                    emmr_pkg::PHY_ADDRESS);

  always_comb begin
    state_nxt     = state_r;
    ping_nxt      = ping_r;
    pong_nxt      = pong_r;
    maddr_nxt     = maddr_r;
    mwr_nxt       = mwr_r;
    mrd_nxt       = mrd_r;
    mctrl_nxt     = mctrl_r;
    mem_rd_op_nxt = mem_rd_op_r;
    rdata_nxt     = rdata_r;
    status_nxt    = status_r;
    st_rd_en      = 1'b0;
    st_rd_idx     = phy_reg;
    st_wr_en      = 1'b0;
    st_wr_idx     = emmr_pkg::PHY_BMCR_IDX;
    st_wr_data    = mwr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        rdata_nxt  = '0;
        status_nxt = emmr_pkg::ST_OK;
        state_nxt  = S_OUT;
        unique case (dec.kind)
          emmr_pkg::ACC_BEYOND:  status_nxt = emmr_pkg::ST_BEYOND;
          emmr_pkg::ACC_NOREAD:  status_nxt = emmr_pkg::ST_NOREAD;
          emmr_pkg::ACC_NOWRITE: status_nxt = emmr_pkg::ST_NOWRITE;
          emmr_pkg::ACC_RD_PING: rdata_nxt = ping_r;
          emmr_pkg::ACC_RD_PONG: rdata_nxt = pong_r;
          emmr_pkg::ACC_RD_MDIO: rdata_nxt = {{(emmr_pkg::DATA_W-emmr_pkg::PHY_DATA_W){1'b0}},
                                              mrd_r};
          emmr_pkg::ACC_RD_CTRL: rdata_nxt = mctrl_r;
          emmr_pkg::ACC_WR_PING: ping_nxt = wdata_r[1] ? {wdata_r[31:2], 2'b00} : wdata_r;
          emmr_pkg::ACC_WR_PONG: pong_nxt = (wdata_r[1] || wdata_r[0]) ?
                                            {wdata_r[31:2], 2'b00} : wdata_r;
          emmr_pkg::ACC_WR_MADDR: maddr_nxt = wdata_r[emmr_pkg::MDIO_ADDR_W-1:0];
          emmr_pkg::ACC_WR_MDATA: mwr_nxt = wdata_r[emmr_pkg::PHY_DATA_W-1:0];
          emmr_pkg::ACC_WR_CTRL: begin
            mctrl_nxt = {wdata_r[31:1], 1'b0};
            if (wdata_r[0]) begin
              if (maddr_r[emmr_pkg::MDIO_ADDR_W-1]) begin
                // MDIO read
                if (phy_hit) begin
                  st_rd_en      = 1'b1;
                  st_rd_idx     = phy_reg;
                  mem_rd_op_nxt = 1'b1;
                  state_nxt     = S_MEM;
                end else begin
                  mrd_nxt = '0;
                end
              end else if (phy_hit) begin
                if (phy_reg != emmr_pkg::PHY_BMCR_IDX) begin
                  status_nxt = emmr_pkg::ST_PHYREG;
                end else if (mwr_r[15]) begin
                  // BMCR reset/autoneg bit: update BMSR instead
                  st_rd_en      = 1'b1;
                  st_rd_idx     = emmr_pkg::PHY_BMSR_IDX;
                  mem_rd_op_nxt = 1'b0;
                  state_nxt     = S_MEM;
                end else begin
                  st_wr_en   = 1'b1;
                  st_wr_idx  = emmr_pkg::PHY_BMCR_IDX;
                  st_wr_data = mwr_r;
                end
              end
            end
          end
          default: ;
        endcase
      end
      S_MEM: begin
        state_nxt = S_OUT;
        if (mem_rd_op_r) begin
          mrd_nxt = st_rd_data;
        end else begin
          st_wr_en   = 1'b1;
          st_wr_idx  = emmr_pkg::PHY_BMSR_IDX;
          st_wr_data = st_rd_data | emmr_pkg::BMSR_SET_BITS;
        end
      end
      S_OUT: begin
        if (out_word.ready) state_nxt = in_fire ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ping_r      <= '0;
      pong_r      <= '0;
      maddr_r     <= '0;
      mwr_r       <= '0;
      mrd_r       <= '0;
      mctrl_r     <= '0;
      mem_rd_op_r <= 1'b0;
      status_r    <= emmr_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      ping_r      <= ping_nxt;
      pong_r      <= pong_nxt;
      maddr_r     <= maddr_nxt;
      mwr_r       <= mwr_nxt;
      mrd_r       <= mrd_nxt;
      mctrl_r     <= mctrl_nxt;
      mem_rd_op_r <= mem_rd_op_nxt;
      status_r    <= status_nxt;
    end
    rdata_r <= rdata_nxt;
    if (in_fire) begin
      cmd_r   <= in_word.command;
      addr_r  <= in_word.byte_address;
      size_r  <= in_word.access_bytes;
      wdata_r <= in_word.write_data;
    end
  end

`ifndef SYNTHESIS
  a_fire_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_EXEC)
    else $error("accepted word not executed next cycle");

  a_mem_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MEM |-> $past(state_r) == S_EXEC)
    else $error("store access stage not entered from execute");

  a_ctrl_go_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !mctrl_r[0])
    else $error("MDIO control start bit left set");

  a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && status_r != emmr_pkg::ST_OK) |-> rdata_r == '0)
    else $error("failed access returns nonzero data");
`endif

endmodule

[rtl/emmr_decode.sv]
// ----------------------------------------------------------------------------
// emmr_decode
// Register map decoder: classifies one access by command, address and size.
// ----------------------------------------------------------------------------
module emmr_decode (
  input  logic                        command,
  input  logic [emmr_pkg::ADDR_W-1:0] byte_address,
  input  logic [emmr_pkg::SIZE_W-1:0] access_bytes,
  output emmr_pkg::dec_t              dec
);

  logic [emmr_pkg::ADDR_W:0] end_addr;
  logic                      beyond;
  logic                      rx_zero;
  logic                      tx_buf;

  assign end_addr = {1'b0, byte_address} + {{(emmr_pkg::ADDR_W-emmr_pkg::SIZE_W+1){1'b0}},
                                            access_bytes};
  assign beyond   = end_addr > (emmr_pkg::ADDR_W+1)'(emmr_pkg::MAP_BYTES);

  assign rx_zero = (byte_address >= emmr_pkg::ADDR_RXA_FIRST &&
                    byte_address <= emmr_pkg::ADDR_RXA_LAST) ||
                   (byte_address >= emmr_pkg::ADDR_RXB_FIRST &&
                    byte_address <= emmr_pkg::ADDR_RXB_LAST);
  assign tx_buf  = (byte_address <= emmr_pkg::ADDR_TXA_LAST) ||
                   (byte_address >= emmr_pkg::ADDR_TXB_FIRST &&
                    byte_address <= emmr_pkg::ADDR_TXB_LAST);

  always_comb begin
    dec.is_write = command;
    if (beyond) begin
      dec.kind = emmr_pkg::ACC_BEYOND;
    end else if (!command) begin
      if (byte_address == emmr_pkg::ADDR_PING_STAT)      dec.kind = emmr_pkg::ACC_RD_PING;
      else if (byte_address == emmr_pkg::ADDR_PONG_STAT) dec.kind = emmr_pkg::ACC_RD_PONG;
      else if (byte_address == emmr_pkg::ADDR_MDIO_RD)   dec.kind = emmr_pkg::ACC_RD_MDIO;
      else if (byte_address == emmr_pkg::ADDR_MDIO_CTRL) dec.kind = emmr_pkg::ACC_RD_CTRL;
      else if (rx_zero)                                  dec.kind = emmr_pkg::ACC_RD_ZERO;
      else                                               dec.kind = emmr_pkg::ACC_NOREAD;
    end else begin
      if (byte_address == emmr_pkg::ADDR_PING_STAT)      dec.kind = emmr_pkg::ACC_WR_PING;
      else if (byte_address == emmr_pkg::ADDR_PONG_STAT) dec.kind = emmr_pkg::ACC_WR_PONG;
      else if (byte_address == emmr_pkg::ADDR_MDIO_CTRL) dec.kind = emmr_pkg::ACC_WR_CTRL;
      else if (byte_address == emmr_pkg::ADDR_MDIO_ADDR) dec.kind = emmr_pkg::ACC_WR_MADDR;
      else if (byte_address == emmr_pkg::ADDR_MDIO_WR)   dec.kind = emmr_pkg::ACC_WR_MDATA;
      else if (byte_address == emmr_pkg::ADDR_PING_LEN ||
               byte_address == emmr_pkg::ADDR_PONG_LEN ||
               byte_address == emmr_pkg::ADDR_RXA_STAT ||
               byte_address == emmr_pkg::ADDR_RXB_STAT || tx_buf)
                                                         dec.kind = emmr_pkg::ACC_WR_NOP;
      else                                               dec.kind = emmr_pkg::ACC_NOWRITE;
    end
  end

endmodule

[rtl/emmr_phy_store.sv]
// ----------------------------------------------------------------------------
// emmr_phy_store
// PHY register file: one write and one registered read port, with per-entry
// valid bits so unwritten entries read back their reset presets.
// ----------------------------------------------------------------------------
module emmr_phy_store (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [emmr_pkg::PHY_IDX_W-1:0]  rd_idx,
  output logic [emmr_pkg::PHY_DATA_W-1:0] rd_data,
  input  logic                            wr_en,
  input  logic [emmr_pkg::PHY_IDX_W-1:0]  wr_idx,
  input  logic [emmr_pkg::PHY_DATA_W-1:0] wr_data
);

  logic [emmr_pkg::PHY_DATA_W-1:0]  mem [emmr_pkg::PHY_REG_CNT];
  logic [emmr_pkg::PHY_REG_CNT-1:0] valid_r;
  logic [emmr_pkg::PHY_DATA_W-1:0]  mem_q_r;
  logic [emmr_pkg::PHY_IDX_W-1:0]   idx_q_r;
  logic                             vld_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_idx];
      idx_q_r <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        vld_q_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : emmr_pkg::phy_preset(idx_q_r);

endmodule
